// ----- hw/rtl/fpba_pkg.sv -----
// Shared constants and codes for the fit-policy block allocator.
package fpba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 32;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SIZE_W     = 16;

    // Field and register widths
    localparam int OP_W    = 2;
    localparam int MODE_W  = 2;
    localparam int BCNT_W  = 6;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // Opcodes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_PASS  = 2'd2;

    // Placement policies
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_FIT_MODE    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

endpackage

// ----- hw/rtl/fpba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fit_policy_block_allocator_top.sv -----
// Fit-policy partition allocator: size table, used marks and scan sequencer.
// Load and new-pass transactions complete on acceptance. An allocate scans
// min(block_count, 32) partitions, then waits in the done state until its result
// can enter the output register; the input reopens as that result is loaded.
// The scan reads one partition per cycle from the size RAM through one shared
// subtract/compare unit, and a result side that holds a previous result keeps
// the allocate in the done state, so no new request is accepted meanwhile.
// Synchronous active-low reset clears used marks, fit_mode, block_count and
// control state; the size table is undefined until loaded.
module fit_policy_block_allocator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fpba_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic [fpba_pkg::CDATA_W-1:0]    i_cfg_data,
    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fpba_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [4:0] block_index, [20:5] size_value
    input  logic [fpba_pkg::OP_W-1:0]       s_axis_tuser,  // [1:0] opcode
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fpba_pkg::M_DATA_W-1:0]   m_axis_tdata,  // [4:0] chosen_block, [20:5] leftover
    output logic                            m_axis_tuser   // [0] found
);

    import fpba_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [MODE_W-1:0]     r_fit_mode;
    logic [BCNT_W-1:0]     r_block_count;
    logic [NUM_BLOCKS-1:0] r_used;
    logic [SIZE_W-1:0]     r_req;
    logic [CNT_W-1:0]      r_rd_idx;
    logic                  r_iss_valid;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_cmp_used;
    logic                  r_have;
    logic [IDX_W-1:0]      r_pick;
    logic [SIZE_W-1:0]     r_pick_left;
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [IDX_W-1:0]      r_out_block;
    logic [SIZE_W-1:0]     r_out_left;

    logic                  in_fire;
    logic [OP_W-1:0]       in_op;
    logic [IDX_W-1:0]      in_idx;
    logic [SIZE_W-1:0]     in_size;
    logic [CNT_W-1:0]      limit;
    logic                  issue;
    logic [SIZE_W-1:0]     rd_size;
    logic [SIZE_W:0]       diff;
    logic                  fits;
    logic                  better;
    logic                  take;
    logic                  out_free;

    // Unpack the request
    assign in_op   = s_axis_tuser;
    assign in_idx  = s_axis_tdata[IDX_W-1:0];
    assign in_size = s_axis_tdata[IDX_W +: SIZE_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Clamp the scan length to the table depth
    assign limit = (r_block_count > BCNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                          : CNT_W'(r_block_count);
    assign issue = (r_state == ST_SCAN) && (r_rd_idx < limit);

    // Partition size table
    fpba_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && (in_op == OP_LOAD)),
        .i_waddr (in_idx),
        .i_wdata (in_size),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd_size)
    );

    // Shared subtract and compare unit
    assign diff = {1'b0, rd_size} - {1'b0, r_req};
    assign fits = !r_cmp_used && !diff[SIZE_W];
    always_comb begin
        case (r_fit_mode)
            MODE_BEST:  better = diff[SIZE_W-1:0] < r_pick_left;
            MODE_WORST: better = diff[SIZE_W-1:0] > r_pick_left;
            default:    better = 1'b0;
        endcase
    end
    assign take = r_iss_valid && fits && (!r_have || better);

    assign out_free = !r_out_valid || m_axis_tready;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && (in_op == OP_ALLOC)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !r_iss_valid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and used marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_fit_mode    <= MODE_FIRST;
            r_block_count <= '0;
            r_used        <= '0;
            r_iss_valid   <= 1'b0;
            r_have        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iss_valid <= issue;

            if (i_cfg_valid) begin
                if (i_cfg_index == REG_FIT_MODE) begin
                    r_fit_mode <= i_cfg_data[MODE_W-1:0];
                end else if (i_cfg_index == REG_BLOCK_COUNT) begin
                    r_block_count <= i_cfg_data[BCNT_W-1:0];
                end
            end

            // Start a scan, track the pick, mark it used on completion, clear marks on a new pass
            if (in_fire && (in_op == OP_ALLOC)) begin
                r_have <= 1'b0;
            end else if (take) begin
                r_have <= 1'b1;
            end
            if (in_fire && (in_op == OP_PASS)) begin
                r_used <= '0;
            end else if ((r_state == ST_DONE) && out_free && r_have) begin
                r_used[r_pick] <= 1'b1;
            end

            // Output register
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan datapath and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire && (in_op == OP_ALLOC)) begin
            r_req    <= in_size;
            r_rd_idx <= '0;
        end else if (issue) begin
            r_rd_idx <= r_rd_idx + CNT_W'(1);
        end
        r_cmp_idx  <= r_rd_idx[IDX_W-1:0];
        r_cmp_used <= r_used[r_rd_idx[IDX_W-1:0]];
        if (take) begin
            r_pick      <= r_cmp_idx;
            r_pick_left <= diff[SIZE_W-1:0];
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out_found <= r_have;
            r_out_block <= r_have ? r_pick : '0;
            r_out_left  <= r_have ? r_pick_left : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {(M_DATA_W-IDX_W-SIZE_W)'(0), r_out_left, r_out_block};

endmodule

// ----- test/tb_fit_policy_block_allocator_top.sv -----
// Self-checking testbench for the fit-policy partition allocator.
`timescale 1ns / 100ps

module tb_fit_policy_block_allocator_top;
    import fpba_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 5;
    // Drain wait, rounded up from the longest allocate
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 4_800_000;
    localparam int BATCH_ITEMS   = 35;
    localparam int PAD_W         = S_DATA_W - SIZE_W - IDX_W;

    // Codes outside the defined sets
    localparam logic [OP_W-1:0]   OP_UNDEFINED   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  block;
        logic [SIZE_W-1:0] leftover;
    } t_alloc_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CIDX_W-1:0]     i_cfg_index;
    logic [CDATA_W-1:0]    i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;

    // Shadow state of the allocator
    logic [SIZE_W-1:0]     part_size [NUM_BLOCKS];
    bit                    part_used [NUM_BLOCKS];
    logic [MODE_W-1:0]     cur_mode;
    logic [BCNT_W-1:0]     cur_count;
    t_alloc_result         expected_allocs[$];

    int                    error_count;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    bit                    holding_results;
    event                  hold_results;

    fit_policy_block_allocator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Scan the free partitions in index order, pick by the current policy and mark the pick used
    function automatic t_alloc_result predict_allocation(input logic [SIZE_W-1:0] request);
        int                limit;
        bit                have;
        int                pick;
        logic [SIZE_W-1:0] pick_left;
        logic [SIZE_W-1:0] left;
        t_alloc_result     res;
        limit     = (cur_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(cur_count);
        have      = 1'b0;
        pick      = 0;
        pick_left = '0;
        res       = '0;
        for (int k = 0; k < limit; k++) begin
            if (!part_used[k] && part_size[k] >= request) begin
                left = part_size[k] - request;
                if (!have) begin
                    have      = 1'b1;
                    pick      = k;
                    pick_left = left;
                    if (cur_mode != MODE_BEST && cur_mode != MODE_WORST)
                        break;
                end else if (cur_mode == MODE_BEST && left < pick_left) begin
                    pick      = k;
                    pick_left = left;
                end else if (cur_mode == MODE_WORST && left > pick_left) begin
                    pick      = k;
                    pick_left = left;
                end
            end
        end
        if (have) begin
            part_used[pick] = 1'b1;
            res.found       = 1'b1;
            res.block       = pick[IDX_W-1:0];
            res.leftover    = pick_left;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Send one request transaction and update the shadow state on acceptance
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [SIZE_W-1:0] size);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, size, idx};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        case (op)
            OP_LOAD:  part_size[idx] = size;
            OP_PASS:  foreach (part_used[k]) part_used[k] = 1'b0;
            OP_ALLOC: expected_allocs.push_back(predict_allocation(size));
            default: ;
        endcase
    endtask

    // Stop offering, wait for every result, then let a trailing scan finish
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_allocs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CIDX_W-1:0] index,
                                  input logic [CDATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == REG_FIT_MODE)
            cur_mode = value[MODE_W-1:0];
        else if (index == REG_BLOCK_COUNT)
            cur_count = value[BCNT_W-1:0];
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input logic [BCNT_W-1:0] count);
        drain();
        write_register(REG_FIT_MODE, CDATA_W'(mode));
        write_register(REG_BLOCK_COUNT, CDATA_W'(count));
        i_cfg_valid <= 1'b0;
    endtask

    // Reset values: zero count finds nothing, undefined opcode is dropped
    task automatic test_reset_state;
        send_request(OP_ALLOC, '0, '0);
        send_request(OP_ALLOC, '1, '1);
        send_request(OP_UNDEFINED, '1, '1);
        send_request(OP_PASS, '0, '0);
        send_request(OP_ALLOC, '0, 16'd1);
    endtask

    // Four scanned partitions with ties, an exact fit and the size extremes
    task automatic test_placement_policies;
        send_request(OP_LOAD, 5'd0, 16'hFFFF);
        send_request(OP_LOAD, 5'd1, 16'd5);
        send_request(OP_LOAD, 5'd2, 16'd5);
        send_request(OP_LOAD, 5'd3, 16'd0);
        send_request(OP_LOAD, 5'd31, 16'h8001);

        configure(MODE_FIRST, 6'd4);
        send_request(OP_ALLOC, '1, 16'd0);
        send_request(OP_ALLOC, '0, 16'hFFFF);
        send_request(OP_ALLOC, '0, 16'd5);
        send_request(OP_PASS, '0, '0);

        configure(MODE_BEST, 6'd4);
        send_request(OP_ALLOC, '0, 16'd5);
        send_request(OP_ALLOC, '0, 16'd0);
        send_request(OP_PASS, '0, '0);

        configure(MODE_WORST, 6'd4);
        send_request(OP_ALLOC, '0, 16'd0);
        send_request(OP_ALLOC, '0, 16'd5);
        send_request(OP_PASS, '0, '0);

        configure(MODE_UNDEFINED, 6'd4);
        send_request(OP_ALLOC, '0, 16'd1);
    endtask

    // Fill the whole table so any count may be scanned from here on
    task automatic test_table_load;
        for (int k = 0; k < NUM_BLOCKS; k++)
            send_request(OP_LOAD, k[IDX_W-1:0], SIZE_W'($urandom_range(16'hFFFF)));
    endtask

    // Random batches: a setting, sometimes a fresh pass, then mostly allocations
    task automatic test_random_traffic(input int batches);
        int                scale;
        int                pick;
        int                roll;
        logic [BCNT_W-1:0] count;
        for (int b = 0; b < batches; b++) begin
            pick = $urandom_range(7);
            case (pick)
                0: count = 6'd0;
                1: count = 6'd1;
                2: count = 6'd2;
                3: count = 6'd32;
                4: count = 6'd33;
                5: count = 6'd63;
                default: count = BCNT_W'($urandom_range(NUM_BLOCKS, 1));
            endcase
            configure(MODE_W'($urandom_range(3)), count);
            case ($urandom_range(2))
                0: scale = 15;
                1: scale = 1023;
                default: scale = 65535;
            endcase
            if ($urandom_range(1))
                send_request(OP_PASS, IDX_W'($urandom), SIZE_W'($urandom));
            for (int n = 0; n < BATCH_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < 20)
                    send_request(OP_LOAD, IDX_W'($urandom_range(NUM_BLOCKS - 1)),
                                 SIZE_W'($urandom_range(scale)));
                else if (roll < 88)
                    send_request(OP_ALLOC, IDX_W'($urandom), SIZE_W'($urandom_range(scale)));
                else if (roll < 96)
                    send_request(OP_PASS, IDX_W'($urandom), SIZE_W'($urandom));
                else
                    send_request(OP_UNDEFINED, IDX_W'($urandom), SIZE_W'($urandom));
            end
        end
    endtask

    // Hold off the result side while allocations keep arriving
    task automatic test_output_backpressure;
        configure(MODE_BEST, 6'd32);
        -> hold_results;
        send_request(OP_PASS, '0, '0);
        for (int n = 0; n < 24; n++)
            send_request(OP_ALLOC, IDX_W'($urandom), SIZE_W'($urandom_range(1023)));
    endtask

    // Count out a long result stall
    initial begin
        holding_results = 1'b0;
        forever begin
            @(hold_results);
            holding_results = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding_results = 1'b0;
        end
    end

    // Randomly stall the result side
    always @(posedge i_clk)
        m_axis_tready <= !holding_results && ($urandom_range(99) >= recv_idle_pct);

    // Compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_allocs.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%0h tuser=%0b",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_allocs.pop_front();
                if (m_axis_tuser !== want.found)
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              m_axis_tuser, want.found));
                if (m_axis_tdata[IDX_W-1:0] !== want.block)
                    report_mismatch($sformatf("chosen_block %0d, expected %0d",
                                              m_axis_tdata[IDX_W-1:0], want.block));
                if (m_axis_tdata[IDX_W+SIZE_W-1:IDX_W] !== want.leftover)
                    report_mismatch($sformatf("leftover %0h, expected %0h",
                                              m_axis_tdata[IDX_W+SIZE_W-1:IDX_W],
                                              want.leftover));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_fit_policy_block_allocator_top: FAIL");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        error_count   = 0;
        cur_mode      = MODE_FIRST;
        cur_count     = '0;
        foreach (part_size[k]) part_size[k] = '0;
        foreach (part_used[k]) part_used[k] = 1'b0;

        send_idle_pct = 36;
        recv_idle_pct = 50;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_placement_policies();
        test_table_load();
        test_random_traffic(5);

        send_idle_pct = 50;
        recv_idle_pct = 36;
        test_random_traffic(5);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(5);
        test_output_backpressure();

        drain();
        if (error_count == 0)
            $display("tb_fit_policy_block_allocator_top: PASS");
        else
            $display("tb_fit_policy_block_allocator_top: FAIL");
        $finish;
    end

endmodule
